// ----- rtl/core/dorc_pkg.sv -----
// Shared widths, constants and handshake types of the digit occurrence range counter.
package dorc_pkg;

    localparam int MAX_DIGITS = 18;
    localparam int VAL_W      = 60;
    localparam int DIG_W      = 4;
    localparam int CNT_W      = 5;
    localparam int BCD_W      = DIG_W * MAX_DIGITS;
    localparam int POS_W      = $clog2(MAX_DIGITS + 1);
    localparam int RAM_DEPTH  = MAX_DIGITS + 1;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);
    localparam int CONV_STEPS = VAL_W;
    localparam int STEP_W     = $clog2(CONV_STEPS + 1);

    // stream payload layout
    localparam int LO_LSB     = 0;
    localparam int HI_LSB     = VAL_W;
    localparam int DIGIT_LSB  = 2 * VAL_W;
    localparam int COUNT_LSB  = 2 * VAL_W + DIG_W;
    localparam int S_FIELDS_W = 2 * VAL_W + DIG_W + CNT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((VAL_W + 7) / 8) * 8;

    localparam logic [DIG_W-1:0] DEC_MAX = 4'd9;

    // largest value that fits in MAX_DIGITS decimal digits
    function automatic logic [VAL_W-1:0] top_value();
        logic [VAL_W-1:0] v;
        v = VAL_W'(1);
        for (int i = 0; i < MAX_DIGITS; i++) begin
            v = v * VAL_W'(10);
        end
        return v - VAL_W'(1);
    endfunction

    localparam logic [VAL_W-1:0] TOP_VALUE = top_value();

    typedef struct packed {
        logic             start;
        logic [DIG_W-1:0] digit;
        logic [CNT_W-1:0] want;
    } dp_cmd_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] count;
    } dp_rsp_t;

endpackage

// ----- rtl/core/dorc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dorc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/dorc_b2d.sv -----
// Binary to BCD converter, one shift-and-adjust step per cycle.
module dorc_b2d (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [dorc_pkg::VAL_W-1:0]  value,
    output logic                        done,
    output logic [dorc_pkg::BCD_W-1:0]  bcd
);
    import dorc_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [VAL_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [BCD_W-1:0]  adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (bcd_reg[i*DIG_W +: DIG_W] >= 4'd5) begin
                adj[i*DIG_W +: DIG_W] = bcd_reg[i*DIG_W +: DIG_W] + 4'd3;
            end else begin
                adj[i*DIG_W +: DIG_W] = bcd_reg[i*DIG_W +: DIG_W];
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (busy_reg) begin
            bcd_next  = {adj[BCD_W-2:0], bin_reg[VAL_W-1]};
            bin_next  = {bin_reg[VAL_W-2:0], 1'b0};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            bin_next  = value;
            bcd_next  = '0;
            step_next = STEP_W'(CONV_STEPS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ----- rtl/core/dorc_dp.sv -----
// Digit DP engine: walks the BCD digits and updates one count entry per cycle while in its compute state.
module dorc_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dorc_pkg::dp_cmd_t          cmd,
    input  logic [dorc_pkg::BCD_W-1:0] bcd,
    output dorc_pkg::dp_rsp_t          rsp
);
    import dorc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRIME = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_COMP  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0] c_reg, c_next;
    logic [VAL_W-1:0]  cur_reg, cur_next;
    logic [VAL_W-1:0]  fin_reg, fin_next;
    logic [VAL_W-1:0]  count_reg, count_next;
    logic              first_reg, first_next;
    logic              z_reg, z_next;
    logic              ts_reg, ts_next;
    logic [CNT_W-1:0]  tc_reg, tc_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [DIG_W-1:0]  digit_reg, digit_next;
    logic [CNT_W-1:0]  want_reg, want_next;

    logic [DIG_W-1:0]  dig_d;
    logic              g_dec, g_mid, lt, mid, d_nz, ts_new;
    logic [DIG_W-1:0]  a0, a1;
    logic [CNT_W-1:0]  c_ext, tc1, extra;
    logic [ADDR_W-1:0] want_a;
    logic [VAL_W-1:0]  lo_in, cur, loose, new_val;
    logic              ram_we;
    logic [ADDR_W-1:0] raddr;
    logic [VAL_W-1:0]  rdata;

    dorc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RAM_DEPTH)
    ) u_ways (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (c_reg),
        .wdata (new_val),
        .raddr (raddr),
        .rdata (rdata)
    );

    // per-position terms of the tight path
    always_comb begin
        dig_d  = bcd_reg[pos_reg*DIG_W +: DIG_W];
        g_dec  = (digit_reg <= DEC_MAX);
        g_mid  = (digit_reg != '0) && g_dec;
        lt     = (digit_reg < dig_d);
        mid    = g_mid && lt;
        d_nz   = (dig_d != '0);
        ts_new = ts_reg || d_nz;
        if (ts_reg) begin
            a0 = dig_d - DIG_W'(lt);
            a1 = DIG_W'(lt);
        end else begin
            a0 = d_nz ? (dig_d - DIG_W'(1) - DIG_W'(mid)) : '0;
            a1 = DIG_W'(mid);
        end
        want_a = want_reg[ADDR_W-1:0];
        c_ext  = CNT_W'(c_reg);
        tc1    = tc_reg + CNT_W'(1);
    end

    // shared update: new = 9 * own + lower entry, or 10 * own entry, plus small terms
    always_comb begin
        extra = '0;
        if (c_ext == tc_reg) begin
            extra = extra + CNT_W'(a0);
        end
        if (c_ext == tc1) begin
            extra = extra + CNT_W'(a1);
        end
        if (z_reg && (c_ext == CNT_W'(0))) begin
            extra = extra + (g_mid ? CNT_W'(8) : CNT_W'(9));
        end
        if (z_reg && g_mid && (c_ext == CNT_W'(1))) begin
            extra = extra + CNT_W'(1);
        end
        lo_in = (first_reg || (c_reg == '0)) ? '0 : rdata;
        cur   = first_reg ? '0 : cur_reg;
        if (g_dec) begin
            loose = (cur << 3) + cur + lo_in;
        end else begin
            loose = (cur << 3) + (cur << 1);
        end
        new_val = loose + VAL_W'(extra);
    end

    always_comb begin
        unique case (state_reg)
            ST_PRIME: raddr = want_a;
            ST_LOAD:  raddr = (want_a != '0) ? want_a - ADDR_W'(1) : '0;
            ST_COMP:  raddr = (c_reg >= ADDR_W'(2)) ? c_reg - ADDR_W'(2) : '0;
            default:  raddr = '0;
        endcase
        ram_we = (state_reg == ST_COMP);
    end

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        pos_next   = pos_reg;
        c_next     = c_reg;
        cur_next   = cur_reg;
        fin_next   = fin_reg;
        count_next = count_reg;
        first_next = first_reg;
        z_next     = z_reg;
        ts_next    = ts_reg;
        tc_next    = tc_reg;
        bcd_next   = bcd_reg;
        digit_next = digit_reg;
        want_next  = want_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    bcd_next   = bcd;
                    digit_next = cmd.digit;
                    want_next  = cmd.want;
                    pos_next   = POS_W'(MAX_DIGITS - 1);
                    first_next = 1'b1;
                    z_next     = 1'b0;
                    ts_next    = 1'b0;
                    tc_next    = '0;
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cur_next   = rdata;
                c_next     = want_a;
                state_next = ST_COMP;
            end
            ST_COMP: begin
                if (c_reg == want_a) begin
                    fin_next = new_val;
                end
                cur_next = lo_in;
                if (c_reg == '0) begin
                    z_next     = z_reg || (!ts_reg && d_nz);
                    ts_next    = ts_new;
                    tc_next    = tc_reg + CNT_W'(ts_new && (dig_d == digit_reg));
                    first_next = 1'b0;
                    if (pos_reg == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        pos_next   = pos_reg - POS_W'(1);
                        state_next = ST_PRIME;
                    end
                end else begin
                    c_next = c_reg - ADDR_W'(1);
                end
            end
            ST_FIN: begin
                count_next = fin_reg + VAL_W'((want_reg == '0) && z_reg)
                           + VAL_W'(tc_reg == want_reg);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        pos_reg   <= pos_next;
        c_reg     <= c_next;
        cur_reg   <= cur_next;
        fin_reg   <= fin_next;
        count_reg <= count_next;
        first_reg <= first_next;
        z_reg     <= z_next;
        ts_reg    <= ts_next;
        tc_reg    <= tc_next;
        bcd_reg   <= bcd_next;
        digit_reg <= digit_next;
        want_reg  <= want_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.count = count_reg;

endmodule

// ----- rtl/core/digit_occurrence_range_counter_core.sv -----
// Top level of the digit occurrence range counter: query sequencer and stream ports.
//
// Each input beat carries a range low..high, a decimal digit and a target count;
// the block returns one beat with how many integers in the range hold that digit
// exactly target_count times (leading zeros never count, zero has no digits).
// The answer is f(high) - f(low - 1), where f is a digit DP over 18 decimal
// positions. high is clamped to 10^18 - 1; low > high returns count 0 with
// empty_range set. One query at a time: s_tready is high only while the
// sequencer idles. Each bound goes through binary to BCD conversion
// (one bit per cycle) and then the DP, whose shared adder updates one count
// entry of the DP table per cycle while it computes. A query with low = 0
// evaluates one bound, otherwise two; a reversed range, a clamped empty range
// or a target_count above 18 finishes without conversion or DP.
// The result sits in an output register, so it can wait for m_tready while the
// next query is accepted and processed.
module digit_occurrence_range_counter_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // range_low [59:0], range_high [119:60], target_digit [123:120],
    // target_count [128:124], zero fill above
    input  logic [dorc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // match_count [59:0], zero fill above
    output logic [dorc_pkg::M_TDATA_W-1:0]  m_tdata,
    // empty_range [0]
    output logic                            m_tuser
);
    import dorc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_CONV  = 3'd3;
    localparam logic [2:0] ST_DP    = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [VAL_W-1:0]     lo_reg, lo_next;
    logic [VAL_W-1:0]     hi_reg, hi_next;
    logic [DIG_W-1:0]     digit_reg, digit_next;
    logic [CNT_W-1:0]     want_reg, want_next;
    logic                 need_lo_reg, need_lo_next;
    logic                 second_reg, second_next;
    logic [VAL_W-1:0]     acc_reg, acc_next;
    logic [VAL_W-1:0]     res_count_reg, res_count_next;
    logic                 res_empty_reg, res_empty_next;
    logic                 conv_start_reg, conv_start_next;
    logic [VAL_W-1:0]     conv_value_reg, conv_value_next;
    logic                 dp_start_reg, dp_start_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    logic                 s_beat;
    logic                 conv_done;
    logic [BCD_W-1:0]     conv_bcd;
    dp_cmd_t              dp_cmd;
    dp_rsp_t              dp_rsp;

    dorc_b2d u_b2d (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start_reg),
        .value   (conv_value_reg),
        .done    (conv_done),
        .bcd     (conv_bcd)
    );

    assign dp_cmd.start = dp_start_reg;
    assign dp_cmd.digit = digit_reg;
    assign dp_cmd.want  = want_reg;

    dorc_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (dp_cmd),
        .bcd     (conv_bcd),
        .rsp     (dp_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;

    always_comb begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        digit_next      = digit_reg;
        want_next       = want_reg;
        need_lo_next    = need_lo_reg;
        second_next     = second_reg;
        acc_next        = acc_reg;
        res_count_next  = res_count_reg;
        res_empty_next  = res_empty_reg;
        conv_start_next = 1'b0;
        conv_value_next = conv_value_reg;
        dp_start_next   = 1'b0;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        // drop the held result once it is taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    lo_next    = s_tdata[LO_LSB +: VAL_W];
                    hi_next    = s_tdata[HI_LSB +: VAL_W];
                    digit_next = s_tdata[DIGIT_LSB +: DIG_W];
                    want_next  = s_tdata[COUNT_LSB +: CNT_W];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // reversed range answers at once, otherwise clamp the top bound
                if (lo_reg > hi_reg) begin
                    res_count_next = '0;
                    res_empty_next = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    res_empty_next = 1'b0;
                    if (hi_reg > TOP_VALUE) begin
                        hi_next = TOP_VALUE;
                    end
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if ((lo_reg > hi_reg) || (want_reg > CNT_W'(MAX_DIGITS))) begin
                    res_count_next = '0;
                    state_next     = ST_OUT;
                end else begin
                    // evaluate f(high) first, keep low - 1 for the second pass
                    conv_start_next = 1'b1;
                    conv_value_next = hi_reg;
                    need_lo_next    = (lo_reg != '0);
                    lo_next         = lo_reg - VAL_W'(1);
                    second_next     = 1'b0;
                    state_next      = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    dp_start_next = 1'b1;
                    state_next    = ST_DP;
                end
            end
            ST_DP: begin
                if (dp_rsp.done) begin
                    if (second_reg) begin
                        res_count_next = acc_reg - dp_rsp.count;
                        state_next     = ST_OUT;
                    end else if (need_lo_reg) begin
                        acc_next        = dp_rsp.count;
                        conv_start_next = 1'b1;
                        conv_value_next = lo_reg;
                        second_next     = 1'b1;
                        state_next      = ST_CONV;
                    end else begin
                        res_count_next = dp_rsp.count;
                        state_next     = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'(res_count_reg);
                    m_tuser_next  = res_empty_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            conv_start_reg <= 1'b0;
            dp_start_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            conv_start_reg <= conv_start_next;
            dp_start_reg   <= dp_start_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        digit_reg      <= digit_next;
        want_reg       <= want_next;
        need_lo_reg    <= need_lo_next;
        second_reg     <= second_next;
        acc_reg        <= acc_next;
        res_count_reg  <= res_count_next;
        res_empty_reg  <= res_empty_next;
        conv_value_reg <= conv_value_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
